### rtl/iwt_pkg.sv
`timescale 1ns / 1ps
package iwt_pkg;

   localparam int unsigned WATCHERS_DEFAULT         = 16;
   localparam int unsigned ENTRIES_PER_LIST_DEFAULT = 64;
   localparam int unsigned PRIORITY_LEVELS_DEFAULT  = 8;

   localparam logic [7:0]  NEVER_VICTIM_WEIGHT = 8'd255;
   localparam logic [31:0] NULL_TARGET         = 32'hFFFF_FFFF;

   localparam logic [2:0] CSR_CLIENT_CAPACITY = 3'd0;
   localparam logic [2:0] CSR_CAPACITY_MIN    = 3'd1;
   localparam logic [2:0] CSR_CAPACITY_MAX    = 3'd2;
   localparam logic [2:0] CSR_SERVER_CAPACITY = 3'd3;
   localparam logic [2:0] CSR_WEIGHT_TABLE    = 3'd4;
   localparam logic [2:0] CSR_NORMAL_PRIORITY = 3'd5;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_UNPIN   = 2'd2,
      OP_UPGRADE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      RS_PRESENT   = 4'd0,
      RS_INSERTED  = 4'd1,
      RS_EVICTED   = 4'd2,
      RS_REJECTED  = 4'd3,
      RS_NULL      = 4'd4,
      RS_REMOVED   = 4'd5,
      RS_NOT_FOUND = 4'd6,
      RS_CHANGED   = 4'd7,
      RS_UNCHANGED = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WRITE2,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type      req_type;
      logic [3:0]  watcher_index;
      logic [31:0] target_id;
      logic [2:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic        accepted;
      status_type  status;
      logic        evicted_valid;
      logic [31:0] evicted_target;
      logic [6:0]  list_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] target;
      logic [2:0]  prio;
   } entry_type;

   typedef struct packed {
      logic [6:0]  capacity;
      logic [63:0] weights;
      logic [2:0]  normal_code;
   } cfg_type;

   function automatic logic [2:0] sat_code(logic [2:0] code, int unsigned levels);
      logic [2:0] top_code;
      top_code = (levels > 8) ? 3'd7 : 3'(levels - 1);
      return (code > top_code) ? top_code : code;
   endfunction

   function automatic logic [7:0] weight_of(logic [63:0] table_bits, logic [2:0] code);
      return table_bits[code * 8 +: 8];
   endfunction

endpackage

### rtl/iwt_csr.sv
`timescale 1ns / 1ps
module iwt_csr #(
   parameter int unsigned ENTRIES_PER_LIST = iwt_pkg::ENTRIES_PER_LIST_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS  = iwt_pkg::PRIORITY_LEVELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output iwt_pkg::cfg_type cfg
);

   localparam logic [6:0] EntCap = (ENTRIES_PER_LIST > 127) ? 7'd127 : 7'(ENTRIES_PER_LIST);

   logic [7:0]  client_ff;
   logic [6:0]  min_ff;
   logic [6:0]  max_ff;
   logic [6:0]  server_ff;
   logic [63:0] weights_ff;
   logic [2:0]  normal_ff;
   logic [7:0]  clamped;
   logic [6:0]  limited;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_ff  <= 8'd64;
         min_ff     <= 7'd1;
         max_ff     <= 7'd64;
         server_ff  <= 7'd64;
         weights_ff <= 64'd506097522914230528;
         normal_ff  <= 3'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            iwt_pkg::CSR_CLIENT_CAPACITY: client_ff  <= csr_wdata[7:0];
            iwt_pkg::CSR_CAPACITY_MIN:    min_ff     <= csr_wdata[6:0];
            iwt_pkg::CSR_CAPACITY_MAX:    max_ff     <= csr_wdata[6:0];
            iwt_pkg::CSR_SERVER_CAPACITY: server_ff  <= csr_wdata[6:0];
            iwt_pkg::CSR_WEIGHT_TABLE:    weights_ff <= csr_wdata;
            iwt_pkg::CSR_NORMAL_PRIORITY: normal_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (client_ff < {1'b0, min_ff}) begin
         clamped = {1'b0, min_ff};
      end else if (client_ff > {1'b0, max_ff}) begin
         clamped = {1'b0, max_ff};
      end else begin
         clamped = client_ff;
      end
      limited = ({1'b0, server_ff} < clamped) ? server_ff : clamped[6:0];
      cfg.capacity    = (EntCap < limited) ? EntCap : limited;
      cfg.weights     = weights_ff;
      cfg.normal_code = iwt_pkg::sat_code(normal_ff, PRIORITY_LEVELS);
   end

endmodule

### rtl/iwt_store.sv
`timescale 1ns / 1ps
module iwt_store #(
   parameter int unsigned DEPTH = iwt_pkg::WATCHERS_DEFAULT * iwt_pkg::ENTRIES_PER_LIST_DEFAULT,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               we,
   input  logic [ADDR_W-1:0]  waddr,
   input  iwt_pkg::entry_type wdata,
   input  logic [ADDR_W-1:0]  raddr,
   output iwt_pkg::entry_type rdata
);

   iwt_pkg::entry_type mem [DEPTH];
   iwt_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/iwt_seq.sv
`timescale 1ns / 1ps
module iwt_seq #(
   parameter int unsigned WATCHERS         = iwt_pkg::WATCHERS_DEFAULT,
   parameter int unsigned ENTRIES_PER_LIST = iwt_pkg::ENTRIES_PER_LIST_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS  = iwt_pkg::PRIORITY_LEVELS_DEFAULT,
   parameter int unsigned DEPTH            = WATCHERS * ENTRIES_PER_LIST,
   parameter int unsigned ADDR_W           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  iwt_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  iwt_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output iwt_pkg::rsp_type   rsp_data,
   output logic               mem_we,
   output logic [ADDR_W-1:0]  mem_waddr,
   output iwt_pkg::entry_type mem_wdata,
   output logic [ADDR_W-1:0]  mem_raddr,
   input  iwt_pkg::entry_type mem_rdata
);

   localparam int unsigned SlotW = (ENTRIES_PER_LIST > 1) ? $clog2(ENTRIES_PER_LIST) : 1;
   localparam int unsigned WIdxW = (WATCHERS > 1) ? $clog2(WATCHERS) : 1;
   localparam int unsigned CntW  = $clog2(ENTRIES_PER_LIST + 1);
   localparam int unsigned CmpW  = (CntW > 7) ? CntW : 7;
   localparam logic [SlotW-1:0]  LastSlot = SlotW'(ENTRIES_PER_LIST - 1);
   localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);

   iwt_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   iwt_pkg::op_type    op_ff, op_in;
   logic [WIdxW-1:0]   wi_ff, wi_in;
   logic [31:0]        tgt_ff, tgt_in;
   logic [2:0]         prio_ff, prio_in;
   logic [SlotW-1:0]   cur_ff, cur_in;
   logic               found_ff, found_in;
   logic [SlotW-1:0]   found_idx_ff, found_idx_in;
   logic [2:0]         found_prio_ff, found_prio_in;
   logic               free_ff, free_in;
   logic [SlotW-1:0]   free_idx_ff, free_idx_in;
   logic               vic_ff, vic_in;
   logic [SlotW-1:0]   vic_idx_ff, vic_idx_in;
   logic [31:0]        vic_tgt_ff, vic_tgt_in;
   logic [7:0]         worst_ff, worst_in;
   logic [SlotW-1:0]   w2_slot_ff, w2_slot_in;
   iwt_pkg::entry_type w2_data_ff, w2_data_in;
   iwt_pkg::rsp_type   res_ff, res_in;
   logic [CntW-1:0]    cnt_ff [WATCHERS];
   logic [CntW-1:0]    cnt_in;
   logic               cnt_we;
   logic               rsp_valid_ff, rsp_valid_in;
   iwt_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [WIdxW-1:0]   wrap_idx;
   logic [7:0]         row_w;
   logic [7:0]         new_w;
   logic [7:0]         found_w;
   logic [CntW-1:0]    cnt_cur;
   iwt_pkg::entry_type new_entry;

   function automatic logic [ADDR_W-1:0] slot_addr(logic [WIdxW-1:0] w, logic [SlotW-1:0] s);
      return ADDR_W'(w * ENTRIES_PER_LIST + s);
   endfunction

   always_comb begin
      wrap_idx = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_data.watcher_index == 4'(i)) begin
            wrap_idx = WIdxW'(i % WATCHERS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iwt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WATCHERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[wi_ff] <= cnt_in;
         end
      end
      op_ff         <= op_in;
      wi_ff         <= wi_in;
      tgt_ff        <= tgt_in;
      prio_ff       <= prio_in;
      cur_ff        <= cur_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_prio_ff <= found_prio_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      vic_ff        <= vic_in;
      vic_idx_ff    <= vic_idx_in;
      vic_tgt_ff    <= vic_tgt_in;
      worst_ff      <= worst_in;
      w2_slot_ff    <= w2_slot_in;
      w2_data_ff    <= w2_data_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      wi_in         = wi_ff;
      tgt_in        = tgt_ff;
      prio_in       = prio_ff;
      cur_in        = cur_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_prio_in = found_prio_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      vic_in        = vic_ff;
      vic_idx_in    = vic_idx_ff;
      vic_tgt_in    = vic_tgt_ff;
      worst_in      = worst_ff;
      w2_slot_in    = w2_slot_ff;
      w2_data_in    = w2_data_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cnt_we        = 1'b0;
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = slot_addr(wi_ff, cur_ff);
      mem_wdata     = '0;
      mem_raddr     = slot_addr(wi_ff, cur_ff + SlotW'(1));

      cnt_cur   = cnt_ff[wi_ff];
      cnt_in    = cnt_cur;
      row_w     = iwt_pkg::weight_of(cfg.weights, mem_rdata.prio);
      new_w     = iwt_pkg::weight_of(cfg.weights, prio_ff);
      found_w   = iwt_pkg::weight_of(cfg.weights, found_prio_ff);
      new_entry = '{valid: 1'b1, target: tgt_ff, prio: prio_ff};

      unique case (state_ff)
         iwt_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LastAddr) begin
               state_in = iwt_pkg::ST_IDLE;
            end
         end
         iwt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_raddr = slot_addr(wrap_idx, '0);
            if (req_valid) begin
               op_in    = req_data.req_type;
               wi_in    = wrap_idx;
               tgt_in   = req_data.target_id;
               prio_in  = iwt_pkg::sat_code(req_data.priority_req, PRIORITY_LEVELS);
               cur_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               vic_in   = 1'b0;
               worst_in = iwt_pkg::NEVER_VICTIM_WEIGHT;
               state_in = iwt_pkg::ST_SCAN;
            end
         end
         iwt_pkg::ST_SCAN: begin
            if (mem_rdata.valid && mem_rdata.target == tgt_ff && !found_ff) begin
               found_in      = 1'b1;
               found_idx_in  = cur_ff;
               found_prio_in = mem_rdata.prio;
            end
            if (!mem_rdata.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cur_ff;
            end
            if (mem_rdata.valid && row_w < worst_ff) begin
               vic_in     = 1'b1;
               vic_idx_in = cur_ff;
               vic_tgt_in = mem_rdata.target;
               worst_in   = row_w;
            end
            cur_in = cur_ff + SlotW'(1);
            if (cur_ff == LastSlot) begin
               state_in = iwt_pkg::ST_DECIDE;
            end
         end
         iwt_pkg::ST_DECIDE: begin
            res_in.accepted       = 1'b0;
            res_in.status         = iwt_pkg::RS_REJECTED;
            res_in.evicted_valid  = 1'b0;
            res_in.evicted_target = '0;
            state_in              = iwt_pkg::ST_DONE;
            priority if (tgt_ff == iwt_pkg::NULL_TARGET) begin
               res_in.status = iwt_pkg::RS_NULL;
            end else if (op_ff == iwt_pkg::OP_ADD) begin
               priority if (found_ff) begin
                  res_in.accepted = 1'b1;
                  res_in.status   = iwt_pkg::RS_PRESENT;
                  if (new_w > found_w) begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_addr(wi_ff, found_idx_ff);
                     mem_wdata = new_entry;
                  end
               end else if (CmpW'(cnt_cur) < CmpW'(cfg.capacity)) begin
                  if (free_ff) begin
                     mem_we          = 1'b1;
                     mem_waddr       = slot_addr(wi_ff, free_idx_ff);
                     mem_wdata       = new_entry;
                     cnt_we          = 1'b1;
                     cnt_in          = cnt_cur + CntW'(1);
                     res_in.accepted = 1'b1;
                     res_in.status   = iwt_pkg::RS_INSERTED;
                  end
               end else if (vic_ff && new_w > worst_ff) begin
                  res_in.accepted       = 1'b1;
                  res_in.status         = iwt_pkg::RS_EVICTED;
                  res_in.evicted_valid  = 1'b1;
                  res_in.evicted_target = vic_tgt_ff;
                  mem_we                = 1'b1;
                  if (free_ff && free_idx_ff < vic_idx_ff) begin
                     mem_waddr          = slot_addr(wi_ff, free_idx_ff);
                     mem_wdata          = new_entry;
                     w2_slot_in         = vic_idx_ff;
                     w2_data_in         = '0;
                     state_in           = iwt_pkg::ST_WRITE2;
                  end else begin
                     mem_waddr = slot_addr(wi_ff, vic_idx_ff);
                     mem_wdata = new_entry;
                  end
               end
            end else if (!found_ff) begin
               res_in.status = iwt_pkg::RS_NOT_FOUND;
            end else begin
               res_in.accepted = 1'b1;
               mem_waddr       = slot_addr(wi_ff, found_idx_ff);
               unique case (op_ff)
                  iwt_pkg::OP_REMOVE: begin
                     res_in.status = iwt_pkg::RS_REMOVED;
                     mem_we        = 1'b1;
                     mem_wdata     = '0;
                     if (cnt_cur != '0) begin
                        cnt_we = 1'b1;
                        cnt_in = cnt_cur - CntW'(1);
                     end
                  end
                  iwt_pkg::OP_UNPIN: begin
                     res_in.status = (found_prio_ff != cfg.normal_code) ?
                                     iwt_pkg::RS_CHANGED : iwt_pkg::RS_UNCHANGED;
                     mem_we        = 1'b1;
                     mem_wdata     = '{valid: 1'b1, target: tgt_ff, prio: cfg.normal_code};
                  end
                  iwt_pkg::OP_UPGRADE: begin
                     if (new_w > found_w) begin
                        res_in.status = iwt_pkg::RS_CHANGED;
                        mem_we        = 1'b1;
                        mem_wdata     = new_entry;
                     end else begin
                        res_in.status = iwt_pkg::RS_UNCHANGED;
                     end
                  end
                  iwt_pkg::OP_ADD: ;
               endcase
            end
            res_in.list_count = 7'(cnt_in);
         end
         iwt_pkg::ST_WRITE2: begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(wi_ff, w2_slot_ff);
            mem_wdata = w2_data_ff;
            state_in  = iwt_pkg::ST_DONE;
         end
         iwt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = iwt_pkg::ST_IDLE;
            end
         end
         default: state_in = iwt_pkg::ST_CLEAR;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/weighted_eviction_interest_table_unit.sv
`timescale 1ns / 1ps
// one request at a time: after acceptance the sequencer scans the list, decides and, when an
// eviction needs a second write, does it; the response then waits for the previous response
// to be taken, and the next request is taken only after the response is registered
// the list scan reads one slot per cycle through the single read port
// reset (synchronous, active high) sets registers to defaults, zeroes list counts and
// starts a clearing pass over all WATCHERS * ENTRIES_PER_LIST entries with req_ready low
module weighted_eviction_interest_table_unit #(
   parameter int unsigned WATCHERS         = iwt_pkg::WATCHERS_DEFAULT,
   parameter int unsigned ENTRIES_PER_LIST = iwt_pkg::ENTRIES_PER_LIST_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS  = iwt_pkg::PRIORITY_LEVELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iwt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iwt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam int unsigned Depth = WATCHERS * ENTRIES_PER_LIST;
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   iwt_pkg::cfg_type   cfg;
   logic               mem_we;
   logic [AddrW-1:0]   mem_waddr;
   logic [AddrW-1:0]   mem_raddr;
   iwt_pkg::entry_type mem_wdata;
   iwt_pkg::entry_type mem_rdata;

   iwt_csr #(
      .ENTRIES_PER_LIST(ENTRIES_PER_LIST),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   iwt_store #(
      .DEPTH (Depth),
      .ADDR_W(AddrW)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   iwt_seq #(
      .WATCHERS        (WATCHERS),
      .ENTRIES_PER_LIST(ENTRIES_PER_LIST),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .DEPTH           (Depth),
      .ADDR_W          (AddrW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .mem_we   (mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

endmodule

### rtl/iwt_checker.sv
`timescale 1ns / 1ps
module iwt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input iwt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_evict_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted_valid |->
         rsp_data.status == iwt_pkg::RS_EVICTED && rsp_data.accepted)
      else $error("eviction reported with wrong status");

   a_null_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == iwt_pkg::RS_NULL |->
         !rsp_data.accepted && !rsp_data.evicted_valid && rsp_data.evicted_target == '0)
      else $error("null target request acted on");

endmodule

bind weighted_eviction_interest_table_unit iwt_checker u_iwt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

### verif/weighted_eviction_interest_table_checker.sv
`timescale 1ns / 1ps
module weighted_eviction_interest_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  iwt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  iwt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);
   import iwt_pkg::*;

   localparam int NW = 16;
   localparam int NE = 64;

   logic        slot_used [NW*NE];
   logic [31:0] slot_target [NW*NE];
   logic [2:0]  slot_code [NW*NE];
   int          list_len [NW];

   logic [7:0]  m_client;
   logic [6:0]  m_min, m_max, m_server;
   logic [63:0] m_weights;
   logic [2:0]  m_normal;

   rsp_type     expected_q [$];

   function automatic logic [7:0] code_weight(logic [2:0] c);
      return m_weights[8*c +: 8];
   endfunction

   function automatic int list_capacity();
      int c;
      c = m_client;
      if (c < m_min) c = m_min;
      else if (c > m_max) c = m_max;
      if (m_server < c) c = m_server;
      if (c > NE) c = NE;
      return c;
   endfunction

   function automatic int find_target(int base, logic [31:0] t);
      for (int i = 0; i < NE; i++)
         if (slot_used[base+i] && slot_target[base+i] == t) return i;
      return -1;
   endfunction

   function automatic int free_slot(int base);
      for (int i = 0; i < NE; i++)
         if (!slot_used[base+i]) return i;
      return -1;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type     o;
      int          w, base, s, victim;
      logic [7:0]  worst;
      logic [2:0]  code;
      o = '0;
      o.status = RS_REJECTED;
      w = r.watcher_index;
      base = w * NE;
      code = r.priority_req;
      if (r.target_id == NULL_TARGET) begin
         o.status = RS_NULL;
      end else if (r.req_type == OP_ADD) begin
         s = find_target(base, r.target_id);
         if (s >= 0) begin
            if (code_weight(code) > code_weight(slot_code[base+s])) slot_code[base+s] = code;
            o.accepted = 1; o.status = RS_PRESENT;
         end else if (list_len[w] < list_capacity()) begin
            s = free_slot(base);
            if (s >= 0) begin
               slot_used[base+s] = 1; slot_target[base+s] = r.target_id;
               slot_code[base+s] = code;
               list_len[w]++;
               o.accepted = 1; o.status = RS_INSERTED;
            end
         end else begin
            victim = -1;
            worst = NEVER_VICTIM_WEIGHT;
            for (int i = 0; i < NE; i++)
               if (slot_used[base+i] && code_weight(slot_code[base+i]) < worst) begin
                  worst = code_weight(slot_code[base+i]);
                  victim = i;
               end
            if (victim >= 0 && code_weight(code) > worst) begin
               o.evicted_valid = 1;
               o.evicted_target = slot_target[base+victim];
               slot_used[base+victim] = 0;
               s = free_slot(base);
               if (s >= 0) begin
                  slot_used[base+s] = 1; slot_target[base+s] = r.target_id;
                  slot_code[base+s] = code;
               end
               o.accepted = 1; o.status = RS_EVICTED;
            end
         end
      end else begin
         s = find_target(base, r.target_id);
         if (s < 0) begin
            o.status = RS_NOT_FOUND;
         end else if (r.req_type == OP_REMOVE) begin
            slot_used[base+s] = 0;
            if (list_len[w] > 0) list_len[w]--;
            o.accepted = 1; o.status = RS_REMOVED;
         end else if (r.req_type == OP_UNPIN) begin
            o.status = (slot_code[base+s] != m_normal) ? RS_CHANGED : RS_UNCHANGED;
            slot_code[base+s] = m_normal;
            o.accepted = 1;
         end else begin
            if (code_weight(code) > code_weight(slot_code[base+s])) begin
               slot_code[base+s] = code; o.status = RS_CHANGED;
            end else begin
               o.status = RS_UNCHANGED;
            end
            o.accepted = 1;
         end
      end
      o.list_count = 7'(list_len[w]);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < NW*NE; i++) slot_used[i] = 0;
         for (int i = 0; i < NW; i++) list_len[i] = 0;
         m_client = 64; m_min = 1; m_max = 64; m_server = 64;
         m_weights = 64'd506097522914230528; m_normal = 1;
         expected_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.accepted !== rsp_data.accepted || e.status !== rsp_data.status ||
                   e.evicted_valid !== rsp_data.evicted_valid ||
                   e.evicted_target !== rsp_data.evicted_target ||
                   e.list_count !== rsp_data.list_count) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_q.push_back(apply_request(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_CLIENT_CAPACITY: m_client = csr_wdata[7:0];
               CSR_CAPACITY_MIN:    m_min = csr_wdata[6:0];
               CSR_CAPACITY_MAX:    m_max = csr_wdata[6:0];
               CSR_SERVER_CAPACITY: m_server = csr_wdata[6:0];
               CSR_WEIGHT_TABLE:    m_weights = csr_wdata;
               CSR_NORMAL_PRIORITY: m_normal = csr_wdata[2:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_q.size();
   end

endmodule

### verif/tb_weighted_eviction_interest_table_unit.sv
`timescale 1ns / 1ps
module tb_weighted_eviction_interest_table_unit;
   import iwt_pkg::*;

   localparam logic [2:0] CSR_INDEX_GUARD = 3'd7;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending_count, rsp_seen;
   int          cycle_count = 0;
   int          sent = 0;
   bit          calm = 0;
   logic [31:0] id_pool [8];

   weighted_eviction_interest_table_unit DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   weighted_eviction_interest_table_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata, .fail_count, .pending_count,
      .rsp_seen
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("weighted_eviction_interest_table_unit regression: fail");
         $finish;
      end
   end

   // response side stall
   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= 16);

   task automatic send_request(op_type op, logic [3:0] w, logic [31:0] t, logic [2:0] p);
      while ($urandom_range(99) < 16 && !calm) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_data <= '{req_type: op, watcher_index: w, target_id: t, priority_req: p};
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] v);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] pick_target();
      int r;
      r = $urandom_range(99);
      if (r < 3) return NULL_TARGET;
      if (r < 8) return $urandom;
      return id_pool[$urandom_range(7)];
   endfunction

   task automatic random_phase(int n, int wmax);
      op_type op;
      for (int i = 0; i < n; i++) begin
         calm = (i >= n/3 && i < n/3 + 60);
         op = op_type'($urandom_range(99) < 55 ? OP_ADD : $urandom_range(3));
         send_request(op, 4'($urandom_range(wmax)), pick_target(), 3'($urandom_range(7)));
      end
      calm = 0;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) id_pool[i] = $urandom & 32'hFFFF_FFFE;
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFE;
      repeat (11) @(posedge clock);
      reset <= 0;
      // small lists so evictions and rejects happen
      write_csr(CSR_CLIENT_CAPACITY, 64'd3);
      write_csr(CSR_WEIGHT_TABLE, 64'hFF07_0605_0403_0201);
      write_csr(CSR_NORMAL_PRIORITY, 64'd1);
      send_request(OP_ADD, 4'd0, 32'h0, 3'd7);
      send_request(OP_ADD, 4'd0, 32'h0, 3'd7);
      send_request(OP_ADD, 4'd0, 32'hFFFF_FFFE, 3'd0);
      send_request(OP_ADD, 4'd0, 32'h1, 3'd0);
      send_request(OP_ADD, 4'd0, 32'h2, 3'd3);
      send_request(OP_ADD, 4'd0, 32'h3, 3'd0);
      send_request(OP_ADD, 4'd0, NULL_TARGET, 3'd3);
      send_request(OP_UPGRADE, 4'd0, 32'h2, 3'd5);
      send_request(OP_UPGRADE, 4'd0, 32'h2, 3'd1);
      send_request(OP_UNPIN, 4'd0, 32'h2, 3'd0);
      send_request(OP_UNPIN, 4'd0, 32'h2, 3'd0);
      send_request(OP_UNPIN, 4'd15, 32'h9, 3'd0);
      send_request(OP_REMOVE, 4'd0, 32'h2, 3'd0);
      send_request(OP_REMOVE, 4'd0, 32'h2, 3'd0);
      send_request(OP_UPGRADE, 4'd15, NULL_TARGET, 3'd7);
      send_request(OP_ADD, 4'd15, 32'hA5A5_5A5A, 3'd7);
      send_request(OP_ADD, 4'd15, 32'h5A5A_A5A5, 3'd7);
      random_phase(400, 3);
      // crossed clamp bounds and server ceiling
      write_csr(CSR_CAPACITY_MIN, 64'd5);
      write_csr(CSR_CAPACITY_MAX, 64'd2);
      write_csr(CSR_CLIENT_CAPACITY, 64'd255);
      write_csr(CSR_NORMAL_PRIORITY, 64'd7);
      random_phase(350, 15);
      write_csr(CSR_CLIENT_CAPACITY, 64'd0);
      write_csr(CSR_SERVER_CAPACITY, 64'd1);
      write_csr(CSR_WEIGHT_TABLE, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(300, 7);
      write_csr(CSR_WEIGHT_TABLE, {$urandom, $urandom});
      write_csr(CSR_SERVER_CAPACITY, 64'd0);
      write_csr(CSR_CAPACITY_MIN, 64'd0);
      write_csr(CSR_NORMAL_PRIORITY, 64'd0);
      random_phase(200, 3);
      write_csr(CSR_CAPACITY_MIN, 64'd64);
      write_csr(CSR_CAPACITY_MAX, 64'd64);
      write_csr(CSR_SERVER_CAPACITY, 64'd64);
      write_csr(CSR_WEIGHT_TABLE, 64'h0001_0203_0405_0607);
      write_csr(CSR_INDEX_GUARD, 64'd0);
      random_phase(680, 15);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("sent %0d requests over five register settings, %0d responses checked",
               sent, rsp_seen);
      if (fail_count == 0) begin
         $display("weighted_eviction_interest_table_unit regression: pass");
      end else begin
         $display("weighted_eviction_interest_table_unit regression: fail");
      end
      $finish;
   end

endmodule
